// File: src/pscs_pkg.sv
// Package for the program-set drive switch: field widths, event kinds,
// status codes and the control structs passed between sequencer and scan unit.
// No dependencies.
`default_nettype none

package pscs_pkg;

    localparam int KIND_W     = 2;
    localparam int PROG_W     = 7;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_PROGRAM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_APPLIED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PROGRAM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic start;
        logic compact;
    } scan_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

`default_nettype wire

// File: src/pscs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pscs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we_i,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
    input  wire logic [WIDTH-1:0]                       wdata_i,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
    output logic      [WIDTH-1:0]                       rdata_o
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem_reg[waddr_i] <= wdata_i;
        end
        rdata_reg <= mem_reg[raddr_i];
    end

    assign rdata_o = rdata_reg;

endmodule

`default_nettype wire

// File: src/pscs_scan.sv
// Scan unit: walks the program table one entry at a time (S_RD, then S_CMP)
// through a single comparator, either searching for a key or compacting it out.
// Depends on pscs_pkg; drives the ports of one pscs_ram.
`default_nettype none

module pscs_scan #(
    parameter int DEPTH = pscs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire pscs_pkg::scan_cmd_t                    cmd_i,
    input  wire logic [pscs_pkg::PROG_W-1:0]            key_i,
    input  wire logic [$clog2(DEPTH+1)-1:0]             count_i,
    output pscs_pkg::scan_stat_t                        stat_o,
    output logic      [$clog2(DEPTH+1)-1:0]             kept_o,
    output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_o,
    input  wire logic [pscs_pkg::PROG_W-1:0]            rdata_i,
    output logic                                        we_o,
    output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_o,
    output logic      [pscs_pkg::PROG_W-1:0]            wdata_o
);

    import pscs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]        state_reg,   state_next;
    logic [CW-1:0]     idx_reg,     idx_next;
    logic [CW-1:0]     kept_reg,    kept_next;
    logic [CW-1:0]     limit_reg,   limit_next;
    logic [PROG_W-1:0] key_reg,     key_next;
    logic              compact_reg, compact_next;
    logic              hit_reg,     hit_next;
    logic              done_reg,    done_next;

    logic match;
    logic last;

    assign match = (rdata_i == key_reg);
    assign last  = ((idx_reg + CW'(1)) == limit_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        kept_next    = kept_reg;
        limit_next   = limit_reg;
        key_next     = key_reg;
        compact_next = compact_reg;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        we_o         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_i.start) begin
                    key_next     = key_i;
                    limit_next   = count_i;
                    compact_next = cmd_i.compact;
                    idx_next     = '0;
                    kept_next    = '0;
                    hit_next     = 1'b0;
                    if (count_i == '0) begin
                        done_next = 1'b1;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (match) begin
                    hit_next = 1'b1;
                end
                if (compact_reg) begin
                    // keep entries that differ, packed down to the kept index
                    if (!match) begin
                        we_o      = 1'b1;
                        kept_next = kept_reg + CW'(1);
                    end
                    if (last) begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                end else if (match || last) begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        idx_reg     <= idx_next;
        kept_reg    <= kept_next;
        limit_reg   <= limit_next;
        key_reg     <= key_next;
        compact_reg <= compact_next;
        hit_reg     <= hit_next;
    end

    assign raddr_o     = idx_reg[AW-1:0];
    assign waddr_o     = kept_reg[AW-1:0];
    assign wdata_o     = rdata_i;
    assign kept_o      = kept_reg;
    assign stat_o.done = done_reg;
    assign stat_o.hit  = hit_reg;

endmodule

`default_nettype wire

// File: src/preset_set_switch_control_top.sv
// Top level of the program-set drive switch: event sequencer, state and
// result registers. Depends on pscs_pkg, pscs_scan and pscs_ram.
`default_nettype none

// Channel   Ports                                           Direction
// -------   ---------------------------------------------   ---------
// s_        s_valid, s_ready, s_kind, s_program_req          event in
// m_        m_valid, m_ready, m_drive_on, m_current_program, result out
//           m_stored_count, m_in_set, m_status
//
// Walk: a program change or a delete that hits walks the held entries
// one at a time through the one comparator and RAM read port, each entry
// taking a read state and a compare state. Save and ignored events skip
// the walk. One event at a time.
// Reset: synchronous, active low; the set comes up empty, no clearing pass
// (only entries below the count are ever read).
// Stalls: a result waits in the output register; the next event is taken
// while it waits, its own result then holds until the register frees.

module preset_set_switch_control_top #(
    parameter int TABLE_DEPTH = pscs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [pscs_pkg::KIND_W-1:0]     s_kind,
    input  wire logic [pscs_pkg::PROG_W-1:0]     s_program_req,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_drive_on,
    output logic      [pscs_pkg::PROG_W-1:0]     m_current_program,
    output logic      [pscs_pkg::COUNT_W-1:0]    m_stored_count,
    output logic                                 m_in_set,
    output logic      [pscs_pkg::STATUS_W-1:0]   m_status
);

    import pscs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_DONE = 2'd2;

    // sequencer and architectural state
    logic [1:0]          state_reg,   state_next;
    logic [KIND_W-1:0]   kind_reg,    kind_next;
    logic [CW-1:0]       count_reg,   count_next;
    logic [PROG_W-1:0]   program_reg, program_next;
    logic                seen_reg,    seen_next;
    logic                drive_reg,   drive_next;
    logic                held_reg,    held_next;   // current program is in the set
    logic [STATUS_W-1:0] status_reg,  status_next;

    // result register
    logic                m_valid_reg,   m_valid_next;
    logic                m_drive_reg,   m_drive_next;
    logic [PROG_W-1:0]   m_program_reg, m_program_next;
    logic [COUNT_W-1:0]  m_count_reg,   m_count_next;
    logic                m_in_set_reg,  m_in_set_next;
    logic [STATUS_W-1:0] m_status_reg,  m_status_next;

    // scan unit and RAM
    scan_cmd_t         scan_cmd;
    scan_stat_t        scan_stat;
    logic [PROG_W-1:0] scan_key;
    logic [CW-1:0]     scan_kept;
    logic [AW-1:0]     scan_raddr;
    logic              scan_we;
    logic [AW-1:0]     scan_waddr;
    logic [PROG_W-1:0] scan_wdata;
    logic [PROG_W-1:0] ram_rdata;
    logic              save_we;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PROG_W-1:0] ram_wdata;

    logic accept;
    logic out_free;
    logic table_full;

    assign s_ready    = (state_reg == T_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        program_next   = program_reg;
        seen_next      = seen_reg;
        drive_next     = drive_reg;
        held_next      = held_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_drive_next   = m_drive_reg;
        m_program_next = m_program_reg;
        m_count_next   = m_count_reg;
        m_in_set_next  = m_in_set_reg;
        m_status_next  = m_status_reg;
        scan_cmd.start   = 1'b0;
        scan_cmd.compact = 1'b0;
        scan_key       = program_reg;
        save_we        = 1'b0;

        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    kind_next = s_kind;
                    unique case (s_kind)
                        KIND_PROGRAM: begin
                            // search the set for the new program
                            seen_next      = 1'b1;
                            program_next   = s_program_req;
                            scan_key       = s_program_req;
                            scan_cmd.start = 1'b1;
                            status_next    = ST_APPLIED;
                            state_next     = T_BUSY;
                        end
                        KIND_SAVE: begin
                            state_next = T_DONE;
                            if (!seen_reg) begin
                                status_next = ST_NO_PROGRAM;
                            end else if (held_reg) begin
                                status_next = ST_NO_CHANGE;
                            end else if (table_full) begin
                                status_next = ST_FULL;
                            end else begin
                                // append at the fill count
                                save_we     = 1'b1;
                                count_next  = count_reg + CW'(1);
                                drive_next  = 1'b1;
                                held_next   = 1'b1;
                                status_next = ST_APPLIED;
                            end
                        end
                        KIND_DELETE: begin
                            if (!seen_reg) begin
                                status_next = ST_NO_PROGRAM;
                                state_next  = T_DONE;
                            end else if (!held_reg) begin
                                status_next = ST_NO_CHANGE;
                                state_next  = T_DONE;
                            end else begin
                                scan_cmd.start   = 1'b1;
                                scan_cmd.compact = 1'b1;
                                status_next      = ST_APPLIED;
                                state_next       = T_BUSY;
                            end
                        end
                        default: begin
                            status_next = ST_NO_CHANGE;
                            state_next  = T_DONE;
                        end
                    endcase
                end
            end
            T_BUSY: begin
                if (scan_stat.done) begin
                    if (kind_reg == KIND_DELETE) begin
                        count_next = scan_kept;
                        drive_next = 1'b0;
                        held_next  = 1'b0;
                    end else begin
                        drive_next = scan_stat.hit;
                        held_next  = scan_stat.hit;
                    end
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_drive_next   = drive_reg;
                    m_program_next = program_reg;
                    m_count_next   = COUNT_W'(count_reg);
                    m_in_set_next  = held_reg;
                    m_status_next  = status_reg;
                    state_next     = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            program_reg <= '0;
            seen_reg    <= 1'b0;
            drive_reg   <= 1'b0;
            held_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            program_reg <= program_next;
            seen_reg    <= seen_next;
            drive_reg   <= drive_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg      <= kind_next;
        status_reg    <= status_next;
        m_drive_reg   <= m_drive_next;
        m_program_reg <= m_program_next;
        m_count_reg   <= m_count_next;
        m_in_set_reg  <= m_in_set_next;
        m_status_reg  <= m_status_next;
    end

    // save writes in the accept cycle, compaction only while busy
    assign ram_we    = save_we || scan_we;
    assign ram_waddr = save_we ? count_reg[AW-1:0] : scan_waddr;
    assign ram_wdata = save_we ? program_reg : scan_wdata;

    pscs_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (scan_cmd),
        .key_i   (scan_key),
        .count_i (count_reg),
        .stat_o  (scan_stat),
        .kept_o  (scan_kept),
        .raddr_o (scan_raddr),
        .rdata_i (ram_rdata),
        .we_o    (scan_we),
        .waddr_o (scan_waddr),
        .wdata_o (scan_wdata)
    );

    pscs_ram #(
        .WIDTH (PROG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .we_i    (ram_we),
        .waddr_i (ram_waddr),
        .wdata_i (ram_wdata),
        .raddr_i (scan_raddr),
        .rdata_o (ram_rdata)
    );

    assign m_valid           = m_valid_reg;
    assign m_drive_on        = m_drive_reg;
    assign m_current_program = m_program_reg;
    assign m_stored_count    = m_count_reg;
    assign m_in_set          = m_in_set_reg;
    assign m_status          = m_status_reg;

endmodule

`default_nettype wire

// File: tb/preset_set_switch_control_top_test.sv
// Self-checking bench for preset_set_switch_control_top: directed table, then
// weighted random events with an in-bench model of the program set.
// Depends on pscs_pkg and the RTL of the block.
`default_nettype none

module preset_set_switch_control_top_test;

    import pscs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int SET_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 1200;
    localparam int LONG_HOLD    = 250;   // cycles of receiver hold-off
    localparam int TAIL_CYCLES  = 60;    // tail for a full-set walk plus output stall
    localparam int REPORT_MAX   = 10;

    // kind value 3 has no meaning in the block; it must come back as no change
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                drive_on;
        logic [PROG_W-1:0]   current_prog;
        logic [COUNT_W-1:0]  count;
        logic                in_set;
        logic [STATUS_W-1:0] status;
    } switch_result_t;

    // One directed row. fill_reps > 0 expands to program change + save pairs
    // on consecutive programs from prog, all checked by the set model.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PROG_W-1:0] prog;
        logic [4:0]        fill_reps;
        logic              typed;
        switch_result_t    want;
    } stim_row_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind        = '0;
    logic [PROG_W-1:0]   s_program_req = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_drive_on;
    logic [PROG_W-1:0]   m_current_program;
    logic [COUNT_W-1:0]  m_stored_count;
    logic                m_in_set;
    logic [STATUS_W-1:0] m_status;

    preset_set_switch_control_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_program_req     (s_program_req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_on        (m_drive_on),
        .m_current_program (m_current_program),
        .m_stored_count    (m_stored_count),
        .m_in_set          (m_in_set),
        .m_status          (m_status)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Program-set model: the bench's own copy of the set and the switch.
    // ------------------------------------------------------------------
    logic [PROG_W-1:0] held_progs [SET_DEPTH];
    int                held_count    = 0;
    logic [PROG_W-1:0] last_prog     = '0;
    logic              prog_seen     = 1'b0;
    logic              drive_engaged = 1'b0;

    switch_result_t    pending_results [$];
    int                mismatches    = 0;
    bit                hold_request  = 1'b0;

    function automatic logic prog_is_held(logic [PROG_W-1:0] p);
        for (int i = 0; i < held_count; i++) begin
            if (held_progs[i] == p) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one event to the model and returns the switch state it leaves.
    function automatic switch_result_t apply_switch_event(logic [KIND_W-1:0] kind,
                                                          logic [PROG_W-1:0] p);
        switch_result_t r;
        int             kept;
        r.status = ST_APPLIED;
        if (kind == KIND_PROGRAM) begin
            prog_seen     = 1'b1;
            last_prog     = p;
            drive_engaged = prog_is_held(p);
        end else if (kind == KIND_SAVE || kind == KIND_DELETE) begin
            if (!prog_seen) begin
                r.status = ST_NO_PROGRAM;
            end else if (kind == KIND_SAVE) begin
                if (prog_is_held(last_prog)) begin
                    r.status = ST_NO_CHANGE;
                end else if (held_count >= SET_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_progs[held_count] = last_prog;
                    held_count++;
                    drive_engaged = 1'b1;
                end
            end else begin
                if (!prog_is_held(last_prog)) begin
                    r.status = ST_NO_CHANGE;
                end else begin
                    // drop every copy, closing up the gaps
                    kept = 0;
                    for (int i = 0; i < held_count; i++) begin
                        if (held_progs[i] != last_prog) begin
                            held_progs[kept] = held_progs[i];
                            kept++;
                        end
                    end
                    held_count    = kept;
                    drive_engaged = 1'b0;
                end
            end
        end else begin
            r.status = ST_NO_CHANGE;
        end
        r.drive_on     = drive_engaged;
        r.current_prog = last_prog;
        r.count        = held_count[COUNT_W-1:0];
        r.in_set       = prog_is_held(last_prog);
        return r;
    endfunction

    function automatic switch_result_t res(logic d, logic [PROG_W-1:0] p,
                                           logic [COUNT_W-1:0] c, logic i,
                                           logic [STATUS_W-1:0] s);
        switch_result_t r;
        r = '{drive_on: d, current_prog: p, count: c, in_set: i, status: s};
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // ------------------------------------------------------------------
    // Event side: one transfer per call, model stepped at acceptance.
    // ------------------------------------------------------------------
    task automatic send_event(logic [KIND_W-1:0] kind, logic [PROG_W-1:0] p,
                              logic typed, switch_result_t want);
        int             gap;
        switch_result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_program_req <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_switch_event(kind, p);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_side
        int  gap;
        bit  held_once;
        held_once = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !held_once) begin
                // long stall so the block backs up and drops s_ready
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 150)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    task automatic report_mismatch(string what, switch_result_t want,
                                   switch_result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s: exp drive=%0d prog=%0d count=%0d in_set=%0d status=%0d",
                     $realtime, what, want.drive_on, want.current_prog, want.count,
                     want.in_set, want.status);
            $display("%0t: %s: got drive=%0d prog=%0d count=%0d in_set=%0d status=%0d",
                     $realtime, what, got.drive_on, got.current_prog, got.count,
                     got.in_set, got.status);
        end
    endtask

    // Every result transfer is checked against the oldest outstanding one.
    always @(posedge aclk) begin
        switch_result_t got;
        switch_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.drive_on     = m_drive_on;
            got.current_prog = m_current_program;
            got.count        = m_stored_count;
            got.in_set       = m_in_set;
            got.status       = m_status;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.drive_on !== want.drive_on ||
                    got.current_prog !== want.current_prog ||
                    got.count !== want.count ||
                    got.in_set !== want.in_set ||
                    got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #(8_000_000);
        $display("preset_set_switch_control_top_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, weighted random, drain.
    // ------------------------------------------------------------------
    stim_row_t         dir_rows [$];
    logic [PROG_W-1:0] prog_pool [24];

    initial begin : event_side
        int                drain;
        int                r;
        int                save_w;
        int                del_w;
        logic [KIND_W-1:0] kind;
        logic [PROG_W-1:0] p;

        dir_rows = '{
            // save and delete before any program change are ignored
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(0, 7'd0,   5'd0,  0, ST_NO_PROGRAM)},
            '{KIND_DELETE,  7'd0,   5'd0,  1'b1, res(0, 7'd0,   5'd0,  0, ST_NO_PROGRAM)},
            '{KIND_UNUSED,  7'd0,   5'd0,  1'b1, res(0, 7'd0,   5'd0,  0, ST_NO_CHANGE)},
            // empty set: drive stays off
            '{KIND_PROGRAM, 7'd127, 5'd0,  1'b1, res(0, 7'd127, 5'd0,  0, ST_APPLIED)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(1, 7'd127, 5'd1,  1, ST_APPLIED)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(1, 7'd127, 5'd1,  1, ST_NO_CHANGE)},
            '{KIND_PROGRAM, 7'd0,   5'd0,  1'b1, res(0, 7'd0,   5'd1,  0, ST_APPLIED)},
            '{KIND_DELETE,  7'd0,   5'd0,  1'b1, res(0, 7'd0,   5'd1,  0, ST_NO_CHANGE)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(1, 7'd0,   5'd2,  1, ST_APPLIED)},
            '{KIND_PROGRAM, 7'd127, 5'd0,  1'b1, res(1, 7'd127, 5'd2,  1, ST_APPLIED)},
            '{KIND_DELETE,  7'd0,   5'd0,  1'b1, res(0, 7'd127, 5'd1,  0, ST_APPLIED)},
            '{KIND_UNUSED,  7'd0,   5'd0,  1'b1, res(0, 7'd127, 5'd1,  0, ST_NO_CHANGE)},
            // fill the set up to its depth with programs 1..15
            '{KIND_PROGRAM, 7'd1,   5'd15, 1'b0, '0},
            '{KIND_PROGRAM, 7'd85,  5'd0,  1'b1, res(0, 7'd85,  5'd16, 0, ST_APPLIED)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(0, 7'd85,  5'd16, 0, ST_FULL)},
            '{KIND_DELETE,  7'd0,   5'd0,  1'b1, res(0, 7'd85,  5'd16, 0, ST_NO_CHANGE)},
            '{KIND_PROGRAM, 7'd42,  5'd0,  1'b1, res(0, 7'd42,  5'd16, 0, ST_APPLIED)},
            '{KIND_PROGRAM, 7'd7,   5'd0,  1'b1, res(1, 7'd7,   5'd16, 1, ST_APPLIED)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(1, 7'd7,   5'd16, 1, ST_NO_CHANGE)},
            // delete from a full set compacts it, save puts it back at the end
            '{KIND_DELETE,  7'd0,   5'd0,  1'b1, res(0, 7'd7,   5'd15, 0, ST_APPLIED)},
            '{KIND_SAVE,    7'd0,   5'd0,  1'b1, res(1, 7'd7,   5'd16, 1, ST_APPLIED)},
            '{KIND_PROGRAM, 7'd1,   5'd0,  1'b0, '0},
            '{KIND_DELETE,  7'd0,   5'd0,  1'b0, '0}
        };

        foreach (prog_pool[i]) prog_pool[i] = PROG_W'($urandom_range(0, 127));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].fill_reps != 0) begin
                for (int k = 0; k < dir_rows[i].fill_reps; k++) begin
                    send_event(KIND_PROGRAM, dir_rows[i].prog + PROG_W'(k), 1'b0, '0);
                    send_event(KIND_SAVE, '0, 1'b0, '0);
                end
            end else begin
                send_event(dir_rows[i].kind, dir_rows[i].prog, dir_rows[i].typed,
                           dir_rows[i].want);
            end
        end

        // the receiver now takes its long hold-off while events keep coming
        hold_request = 1'b1;

        save_w = 30;
        del_w  = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every 150 events, pick at random between filling and draining the set
            if (n % 150 == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    save_w = 40; del_w = 10;
                end else begin
                    save_w = 15; del_w = 35;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 100 - save_w - del_w - 4) kind = KIND_PROGRAM;
            else if (r < 100 - del_w - 4)     kind = KIND_SAVE;
            else if (r < 96)                  kind = KIND_DELETE;
            else                              kind = KIND_UNUSED;
            // program_req is don't-care apart from program changes; keep it random
            if ($urandom_range(0, 3) == 0)
                p = PROG_W'($urandom_range(0, 127));
            else
                p = prog_pool[$urandom_range(0, 23)];
            send_event(kind, p, 1'b0, '0);
        end
        s_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 100_000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0)
            $display("%0t: %0d results never arrived", $realtime,
                     pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("preset_set_switch_control_top_test: done, clean");
        else
            $display("preset_set_switch_control_top_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
